@@ rtl/srl_pkg.sv @@
// Shared types, constants and helper functions of the S-record loader.
package srl_pkg;

  localparam int unsigned AddrBitsDefault    = 16;
  localparam int unsigned RecordBytesDefault = 256;
  localparam int unsigned BankCount          = 3;
  localparam int unsigned CountBits          = 9;

  localparam logic [7:0] CharS      = 8'h53;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperF = 8'h46;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerF = 8'h66;

  localparam logic [7:0] SumGood   = 8'hFF;
  localparam logic [7:0] MinLength = 8'd3;

  localparam logic [3:0] TypeHeader   = 4'd0;
  localparam logic [3:0] TypeProgram  = 4'd1;
  localparam logic [3:0] TypeRegister = 4'd3;
  localparam logic [3:0] TypeStart    = 4'd9;

  typedef enum logic [0:0] {
    OP_CHAR = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    BANK_PROGRAM  = 2'd0,
    BANK_DATA     = 2'd1,
    BANK_REGISTER = 2'd2,
    BANK_NONE     = 2'd3
  } bank_e;

  typedef enum logic [2:0] {
    STAT_BUSY  = 3'd0,
    STAT_OK    = 3'd1,
    STAT_NO_S  = 3'd2,
    STAT_TYPE  = 3'd3,
    STAT_CSUM  = 3'd4,
    STAT_HEX   = 3'd5,
    STAT_SHORT = 3'd6
  } status_e;

  typedef struct packed {
    logic        operation;
    logic [7:0]  character;
    logic [1:0]  read_bank;
    logic [15:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] program_counter;
    logic [7:0]  read_data;
  } out_item_t;

  typedef struct packed {
    logic                 valid;
    logic [1:0]           bank;
    logic                 stride2;
    logic [15:0]          address;
    logic [CountBits-1:0] count;
  } copy_req_t;

  // Returns a valid flag above the nibble value of one hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= CharZero && c <= CharNine) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CharUpperA && c <= CharUpperF) ||
                 (c >= CharLowerA && c <= CharLowerF)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

@@ rtl/srl_stream_if.sv @@
// Valid/ready channel that carries one word of a given payload type.
interface srl_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/srl_bank_mem.sv @@
// Target memory holding the program, data and register banks.
module srl_bank_mem import srl_pkg::*; #(
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [ADDR_BITS+1:0] wr_addr_i,
  input  logic [7:0]           wr_data_i,
  input  logic                 rd_en_i,
  input  logic [ADDR_BITS+1:0] rd_addr_i,
  output logic [7:0]           rd_data_o
);

  localparam int unsigned Depth = BankCount * (2 ** ADDR_BITS);

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/srl_copy.sv @@
// Record buffer and the sequencer that copies a checked record into its bank.
module srl_copy import srl_pkg::*; #(
  parameter int unsigned ADDR_BITS    = AddrBitsDefault,
  parameter int unsigned RECORD_BYTES = RecordBytesDefault,
  localparam int unsigned IdxBits     = $clog2(RECORD_BYTES)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 buf_we_i,
  input  logic [IdxBits-1:0]   buf_idx_i,
  input  logic [7:0]           buf_data_i,
  input  copy_req_t            copy_req_i,
  output logic                 busy_o,
  output logic                 mem_we_o,
  output logic [ADDR_BITS+1:0] mem_addr_o,
  output logic [7:0]           mem_data_o
);

  logic [7:0]           buf_q [RECORD_BYTES];
  logic [7:0]           rdata_q;
  logic                 active_q;
  logic [CountBits-1:0] left_q;
  logic                 wr_pend_q;
  logic [IdxBits-1:0]   idx_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [1:0]           bank_q;
  logic                 stride2_q;
  logic                 issue;
  logic [ADDR_BITS-1:0] step;

  assign issue = active_q && (left_q != '0);
  assign step  = {{(ADDR_BITS-2){1'b0}}, stride2_q, !stride2_q};

  always_ff @(posedge clk_i) begin
    if (buf_we_i) begin
      buf_q[buf_idx_i] <= buf_data_i;
    end
    if (issue) begin
      rdata_q <= buf_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      left_q    <= '0;
      wr_pend_q <= 1'b0;
    end else if (copy_req_i.valid) begin
      active_q  <= 1'b1;
      left_q    <= copy_req_i.count;
      wr_pend_q <= 1'b0;
    end else if (active_q) begin
      active_q  <= issue;
      left_q    <= issue ? left_q - CountBits'(1) : left_q;
      wr_pend_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (copy_req_i.valid) begin
      idx_q     <= '0;
      addr_q    <= copy_req_i.address[ADDR_BITS-1:0];
      bank_q    <= copy_req_i.bank;
      stride2_q <= copy_req_i.stride2;
    end else begin
      if (issue) begin
        idx_q <= idx_q + IdxBits'(1);
      end
      if (wr_pend_q) begin
        addr_q <= addr_q + step;
      end
    end
  end

  assign busy_o     = active_q;
  assign mem_we_o   = wr_pend_q;
  assign mem_addr_o = {bank_q, addr_q};
  assign mem_data_o = rdata_q;

endmodule

@@ rtl/srl_parser.sv @@
// Character parser: record framing, hex pairs, checksum and sticky errors.
module srl_parser import srl_pkg::*; #(
  parameter int unsigned RECORD_BYTES = RecordBytesDefault,
  localparam int unsigned IdxBits     = $clog2(RECORD_BYTES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               char_valid_i,
  input  logic [7:0]         character_i,
  output logic [2:0]         status_o,
  output logic [15:0]        pc_next_o,
  output logic [2:0]         error_o,
  output logic               buf_we_o,
  output logic [IdxBits-1:0] buf_idx_o,
  output logic [7:0]         buf_data_o,
  output copy_req_t          copy_req_o
);

  typedef enum logic [7:0] {
    PH_WAIT_S = 8'b0000_0001,
    PH_TYPE   = 8'b0000_0010,
    PH_SKIP   = 8'b0000_0100,
    PH_LEN    = 8'b0000_1000,
    PH_AHI    = 8'b0001_0000,
    PH_ALO    = 8'b0010_0000,
    PH_DATA   = 8'b0100_0000,
    PH_CSUM   = 8'b1000_0000
  } phase_e;

  localparam logic [CountBits-1:0] RecordLimit = CountBits'(RECORD_BYTES);

  phase_e               phase_q, phase_d;
  logic [3:0]           nib_q, nib_d;
  logic                 pend_q, pend_d;
  logic [3:0]           type_q, type_d;
  logic [7:0]           left_q, left_d;
  logic [15:0]          addr_q, addr_d;
  logic [7:0]           sum_q, sum_d;
  logic [7:0]           count_q, count_d;
  logic [15:0]          pc_q, pc_d;
  status_e              err_q, err_d;
  status_e              status;
  logic [4:0]           hex;
  logic [7:0]           byte_val;
  logic [7:0]           sum_next;
  logic [7:0]           left_dec;
  logic [CountBits-1:0] count_ext;
  logic [CountBits-1:0] copy_len;
  logic                 buf_we;
  copy_req_t            copy_req;

  always_comb begin
    phase_d   = phase_q;
    nib_d     = nib_q;
    pend_d    = pend_q;
    type_d    = type_q;
    left_d    = left_q;
    addr_d    = addr_q;
    sum_d     = sum_q;
    count_d   = count_q;
    pc_d      = pc_q;
    err_d     = err_q;
    status    = STAT_BUSY;
    buf_we    = 1'b0;
    copy_req  = '0;
    hex       = hex_decode(character_i);
    byte_val  = {nib_q, hex[3:0]};
    sum_next  = sum_q + byte_val;
    left_dec  = left_q - 8'd1;
    count_ext = {{(CountBits-8){1'b0}}, count_q};
    copy_len  = (count_ext > RecordLimit) ? RecordLimit : count_ext;
    if (char_valid_i) begin
      if (err_q != STAT_BUSY) begin
        status = err_q;
      end else begin
        case (phase_q)
          PH_WAIT_S: begin
            if (character_i == CharS) begin
              phase_d = PH_TYPE;
            end else if (character_i != CharLf && character_i != CharCr) begin
              err_d  = STAT_NO_S;
              status = STAT_NO_S;
            end
          end
          PH_TYPE: begin
            if (character_i < CharZero || character_i > CharNine) begin
              err_d  = STAT_TYPE;
              status = STAT_TYPE;
            end else begin
              type_d  = character_i[3:0];
              sum_d   = 8'd0;
              count_d = 8'd0;
              pend_d  = 1'b0;
              phase_d = (character_i[3:0] == TypeHeader) ? PH_SKIP : PH_LEN;
            end
          end
          PH_SKIP: begin
            if (character_i == CharLf) begin
              phase_d = PH_WAIT_S;
            end
          end
          default: begin
            if (!hex[4]) begin
              err_d  = STAT_HEX;
              status = STAT_HEX;
            end else if (!pend_q) begin
              nib_d  = hex[3:0];
              pend_d = 1'b1;
            end else begin
              pend_d = 1'b0;
              sum_d  = sum_next;
              case (phase_q)
                PH_LEN: begin
                  if (byte_val < MinLength) begin
                    err_d  = STAT_SHORT;
                    status = STAT_SHORT;
                  end else begin
                    left_d  = byte_val;
                    phase_d = PH_AHI;
                  end
                end
                PH_AHI: begin
                  addr_d  = {byte_val, 8'h00};
                  left_d  = left_dec;
                  phase_d = PH_ALO;
                end
                PH_ALO: begin
                  addr_d  = {addr_q[15:8], byte_val};
                  left_d  = left_dec;
                  phase_d = (left_dec <= 8'd1) ? PH_CSUM : PH_DATA;
                end
                PH_DATA: begin
                  buf_we  = (count_ext < RecordLimit);
                  count_d = count_q + 8'd1;
                  left_d  = left_dec;
                  if (left_dec <= 8'd1) begin
                    phase_d = PH_CSUM;
                  end
                end
                PH_CSUM: begin
                  if (sum_next != SumGood) begin
                    err_d  = STAT_CSUM;
                    status = STAT_CSUM;
                  end else begin
                    status  = STAT_OK;
                    phase_d = PH_SKIP;
                    if (type_q == TypeStart) begin
                      pc_d = addr_q;
                    end else if (type_q >= TypeProgram && type_q <= TypeRegister &&
                                 copy_len != '0) begin
                      copy_req.valid   = 1'b1;
                      copy_req.bank    = 2'(type_q - TypeProgram);
                      copy_req.stride2 = (type_q == TypeRegister);
                      copy_req.address = addr_q;
                      copy_req.count   = copy_len;
                    end
                  end
                end
                default: begin
                  phase_d = PH_WAIT_S;
                end
              endcase
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_S;
      nib_q   <= 4'd0;
      pend_q  <= 1'b0;
      type_q  <= 4'd0;
      left_q  <= 8'd0;
      addr_q  <= 16'd0;
      sum_q   <= 8'd0;
      count_q <= 8'd0;
      pc_q    <= 16'd0;
      err_q   <= STAT_BUSY;
    end else begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
      pend_q  <= pend_d;
      type_q  <= type_d;
      left_q  <= left_d;
      addr_q  <= addr_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      pc_q    <= pc_d;
      err_q   <= err_d;
    end
  end

  assign status_o   = status;
  assign pc_next_o  = pc_d;
  assign error_o    = err_q;
  assign buf_we_o   = buf_we;
  assign buf_idx_o  = count_q[IdxBits-1:0];
  assign buf_data_o = byte_val;
  assign copy_req_o = copy_req;

endmodule

@@ rtl/srecord_loader.sv @@
// Top level of the S-record loader: handshake, control and result queue.
//
//   Channel | Side   | Word
//   in_i    | sink   | operation, character, read_bank, read_address
//   out_o   | source | status, program_counter, read_data
//
// A read word holds further input off for the registered read port of the bank memory.
// The checksum character of an S1, S2 or S3 record with buffered data bytes holds
// further input off while they are copied, one bank write per cycle.
// Reset clears the control state only; memory contents are undefined until written.
// A two-word result queue lets input words be taken while results wait downstream.
module srecord_loader import srl_pkg::*; #(
  parameter int unsigned ADDR_BITS    = AddrBitsDefault,
  parameter int unsigned RECORD_BYTES = RecordBytesDefault
) (
  input logic          clk_i,
  input logic          rst_ni,
  srl_stream_if.sink   in_i,
  srl_stream_if.source out_o
);

  localparam int unsigned IdxBits = $clog2(RECORD_BYTES);

  typedef enum logic [2:0] {
    CTRL_IDLE = 3'b001,
    CTRL_READ = 3'b010,
    CTRL_COPY = 3'b100
  } ctrl_e;

  ctrl_e                state_q, state_d;
  logic                 in_acc;
  logic                 char_valid;
  logic                 rd_en;
  logic                 bank_none_q;
  logic [2:0]           char_status;
  logic [15:0]          pc_next;
  logic [2:0]           error_code;
  logic                 buf_we;
  logic [IdxBits-1:0]   buf_idx;
  logic [7:0]           buf_data;
  copy_req_t            copy_req;
  logic                 copy_busy;
  logic                 mem_we;
  logic [ADDR_BITS+1:0] mem_waddr;
  logic [7:0]           mem_wdata;
  logic [7:0]           mem_rdata;
  out_item_t            oq_q [2];
  logic                 wr_ptr_q;
  logic                 rd_ptr_q;
  logic [1:0]           cnt_q;
  logic                 push;
  logic                 pop;
  out_item_t            push_item;

  assign in_i.ready = (state_q == CTRL_IDLE) && (cnt_q != 2'd2);
  assign in_acc     = in_i.valid && in_i.ready;
  assign char_valid = in_acc && (in_i.payload.operation == OP_CHAR);
  assign rd_en      = in_acc && (in_i.payload.operation == OP_READ) &&
                      (in_i.payload.read_bank != BANK_NONE);

  srl_parser #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_valid_i(char_valid),
    .character_i (in_i.payload.character),
    .status_o    (char_status),
    .pc_next_o   (pc_next),
    .error_o     (error_code),
    .buf_we_o    (buf_we),
    .buf_idx_o   (buf_idx),
    .buf_data_o  (buf_data),
    .copy_req_o  (copy_req)
  );

  srl_copy #(
    .ADDR_BITS   (ADDR_BITS),
    .RECORD_BYTES(RECORD_BYTES)
  ) u_copy (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .buf_we_i  (buf_we),
    .buf_idx_i (buf_idx),
    .buf_data_i(buf_data),
    .copy_req_i(copy_req),
    .busy_o    (copy_busy),
    .mem_we_o  (mem_we),
    .mem_addr_o(mem_waddr),
    .mem_data_o(mem_wdata)
  );

  srl_bank_mem #(
    .ADDR_BITS(ADDR_BITS)
  ) u_bank_mem (
    .clk_i    (clk_i),
    .wr_en_i  (mem_we),
    .wr_addr_i(mem_waddr),
    .wr_data_i(mem_wdata),
    .rd_en_i  (rd_en),
    .rd_addr_i({in_i.payload.read_bank, in_i.payload.read_address[ADDR_BITS-1:0]}),
    .rd_data_o(mem_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      CTRL_IDLE: begin
        if (in_acc && in_i.payload.operation == OP_READ) begin
          state_d = CTRL_READ;
        end else if (char_valid && copy_req.valid) begin
          state_d = CTRL_COPY;
        end
      end
      CTRL_READ: begin
        state_d = CTRL_IDLE;
      end
      CTRL_COPY: begin
        if (!copy_busy) begin
          state_d = CTRL_IDLE;
        end
      end
      default: begin
        state_d = CTRL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bank_none_q <= (in_i.payload.read_bank == BANK_NONE);
    end
  end

  always_comb begin
    push_item.program_counter = pc_next;
    if (state_q == CTRL_READ) begin
      push = 1'b1;
      push_item.status    = error_code;
      push_item.read_data = bank_none_q ? 8'd0 : mem_rdata;
    end else begin
      push = char_valid;
      push_item.status    = char_status;
      push_item.read_data = 8'd0;
    end
  end

  assign out_o.valid   = (cnt_q != 2'd0);
  assign out_o.payload = oq_q[rd_ptr_q];
  assign pop           = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      oq_q[wr_ptr_q] <= push_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= CTRL_IDLE;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/srl_checker.sv @@
// Port-level checks of the S-record loader and their binding to the top level.
module srl_checker import srl_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_status_i,
  input logic [15:0] out_pc_i,
  input logic [7:0]  out_data_i
);

  logic        in_acc;
  logic        out_acc;
  logic [1:0]  pending_q;
  logic        err_seen_q;
  logic [2:0]  err_q;
  logic [15:0] pc_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= 2'd0;
      err_seen_q <= 1'b0;
      err_q      <= 3'd0;
      pc_q       <= 16'd0;
    end else begin
      pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc && !err_seen_q && out_status_i >= STAT_NO_S) begin
        err_seen_q <= 1'b1;
        err_q      <= out_status_i;
      end
      if (out_acc) begin
        pc_q <= out_pc_i;
      end
    end
  end

  // A waiting word holds still until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_status_i) && $stable(out_pc_i) && $stable(out_data_i))
    else $error("result word changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 2'd0)
    else $error("result word offered with no input word outstanding");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && err_seen_q |-> out_status_i == err_q)
    else $error("error status did not stick");

  a_pc_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_pc_i != pc_q |-> out_status_i == STAT_OK)
    else $error("program counter changed without an accepted record");

endmodule

bind srecord_loader srl_checker u_srl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_status_i(out_o.payload.status),
  .out_pc_i    (out_o.payload.program_counter),
  .out_data_i  (out_o.payload.read_data)
);

@@ tb/srecord_loader_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the S-record loader: record text and reads in, results compared.
module srecord_loader_tb;
  import srl_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT_S,
    PH_TYPE,
    PH_SKIP,
    PH_LEN,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_DATA,
    PH_CSUM
  } phase_e;

  localparam logic [3:0] TypeData       = 4'd2;
  localparam logic [3:0] TypeCheckFirst = 4'd4;
  localparam logic [3:0] TypeCheckLast  = 4'd8;
  localparam int         BankSize       = 1 << AddrBitsDefault;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #10 clk_i = ~clk_i;

  srl_stream_if #(.payload_t(in_item_t))  in_ch ();
  srl_stream_if #(.payload_t(out_item_t)) out_ch ();

  srecord_loader dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  phase_e      scan_phase  = PH_WAIT_S;
  logic [3:0]  nibble_hi   = '0;
  logic        nibble_held = 1'b0;
  logic [3:0]  rec_type    = '0;
  logic [7:0]  bytes_left  = '0;
  logic [15:0] load_addr   = '0;
  logic [7:0]  byte_sum    = '0;
  logic [7:0]  data_count  = '0;
  logic [7:0]  rec_bytes [256];
  logic [7:0]  bank_bytes [int];
  int          written_keys [$];
  logic [15:0] start_pc    = '0;
  status_e     sticky_err  = STAT_BUSY;

  out_item_t awaited_results [$];
  int        words_sent      = 0;
  int        mismatches      = 0;
  int        sender_idle_pct = 0;
  int        sink_stall_pct  = 0;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= CharZero && c <= CharNine) return int'(c) - int'(CharZero);
    if (c >= CharUpperA && c <= CharUpperF) return int'(c) - int'(CharUpperA) + 10;
    if (c >= CharLowerA && c <= CharLowerF) return int'(c) - int'(CharLowerA) + 10;
    return -1;
  endfunction

  function automatic void commit_record();
    int          base;
    logic [15:0] a;
    if (rec_type == TypeStart) begin
      start_pc = load_addr;
      return;
    end
    if (rec_type < TypeProgram || rec_type > TypeRegister) return;
    base = int'(rec_type - TypeProgram) * BankSize;
    a = load_addr;
    for (int i = 0; i < int'(data_count); i++) begin
      if (!bank_bytes.exists(base + int'(a))) written_keys.push_back(base + int'(a));
      bank_bytes[base + int'(a)] = rec_bytes[i];
      a = a + ((rec_type == TypeRegister) ? 16'd2 : 16'd1);
    end
  endfunction

  function automatic status_e feed_char(input logic [7:0] c);
    int         h;
    logic [7:0] b;
    case (scan_phase)
      PH_WAIT_S: begin
        if (c == CharS) scan_phase = PH_TYPE;
        else if (c != CharLf && c != CharCr) sticky_err = STAT_NO_S;
        return sticky_err;
      end
      PH_TYPE: begin
        if (c < CharZero || c > CharNine) begin
          sticky_err = STAT_TYPE;
          return sticky_err;
        end
        rec_type = c[3:0];
        byte_sum = '0;
        data_count = '0;
        nibble_held = 1'b0;
        scan_phase = (rec_type == TypeHeader) ? PH_SKIP : PH_LEN;
        return STAT_BUSY;
      end
      PH_SKIP: begin
        if (c == CharLf) scan_phase = PH_WAIT_S;
        return STAT_BUSY;
      end
      default: ;
    endcase
    h = hex_nibble(c);
    if (h < 0) begin
      sticky_err = STAT_HEX;
      return sticky_err;
    end
    if (!nibble_held) begin
      nibble_hi = h[3:0];
      nibble_held = 1'b1;
      return STAT_BUSY;
    end
    nibble_held = 1'b0;
    b = {nibble_hi, h[3:0]};
    byte_sum += b;
    case (scan_phase)
      PH_LEN: begin
        if (b < MinLength) begin
          sticky_err = STAT_SHORT;
          return sticky_err;
        end
        bytes_left = b;
        scan_phase = PH_ADDR_HI;
      end
      PH_ADDR_HI: begin
        load_addr = {b, 8'h00};
        bytes_left--;
        scan_phase = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        load_addr[7:0] = b;
        bytes_left--;
        scan_phase = (bytes_left <= 8'd1) ? PH_CSUM : PH_DATA;
      end
      PH_DATA: begin
        rec_bytes[data_count] = b;
        data_count++;
        bytes_left--;
        if (bytes_left <= 8'd1) scan_phase = PH_CSUM;
      end
      PH_CSUM: begin
        if (byte_sum != SumGood) begin
          sticky_err = STAT_CSUM;
          return sticky_err;
        end
        commit_record();
        scan_phase = PH_SKIP;
        return STAT_OK;
      end
      default: scan_phase = PH_WAIT_S;
    endcase
    return STAT_BUSY;
  endfunction

  function automatic out_item_t loader_result(input in_item_t w);
    out_item_t r;
    int        key;
    r = '0;
    if (w.operation == OP_READ) begin
      key = int'(w.read_bank) * BankSize + int'(w.read_address);
      if (w.read_bank != BANK_NONE && bank_bytes.exists(key)) r.read_data = bank_bytes[key];
      r.status = sticky_err;
    end else if (sticky_err != STAT_BUSY) begin
      r.status = sticky_err;
    end else begin
      r.status = feed_char(w.character);
    end
    r.program_counter = start_pc;
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CharZero + n;
    return (($urandom_range(1) != 0) ? CharLowerA : CharUpperA) + n - 4'd10;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    c = 8'($urandom);
    while (c == CharLf) c = 8'($urandom);
    return c;
  endfunction

  task automatic send_word(input in_item_t w);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    awaited_results.push_back(loader_result(w));
    words_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    in_item_t w;
    w.operation = OP_CHAR;
    w.character = c;
    w.read_bank = 2'($urandom);
    w.read_address = 16'($urandom);
    send_word(w);
  endtask

  task automatic send_read(input logic [1:0] bank, input logic [15:0] addr);
    in_item_t w;
    w.operation = OP_READ;
    w.character = 8'($urandom);
    w.read_bank = bank;
    w.read_address = addr;
    send_word(w);
  endtask

  task automatic send_hex_byte(input logic [7:0] b);
    send_char(hex_char(b[7:4]));
    send_char(hex_char(b[3:0]));
  endtask

  task automatic end_line();
    case ($urandom_range(3))
      0: send_char(CharLf);
      1: begin
        send_char(CharCr);
        send_char(CharLf);
      end
      2: begin
        repeat ($urandom_range(1, 4)) send_char(junk_char());
        send_char(CharLf);
      end
      default: begin
        send_char(CharLf);
        send_char(CharCr);
        send_char(CharLf);
      end
    endcase
  endtask

  // A corrupted record sends the plain sum as its checksum byte, so the byte sum is even and can never be 0xFF.
  task automatic send_record(input logic [3:0] rtype, input logic [15:0] addr,
                             input logic [7:0] data [$], input bit corrupt = 1'b0);
    logic [7:0] len;
    logic [7:0] sum;
    len = 8'(data.size() + 3);
    sum = len + addr[15:8] + addr[7:0];
    send_char(CharS);
    send_char(CharZero + rtype);
    send_hex_byte(len);
    send_hex_byte(addr[15:8]);
    send_hex_byte(addr[7:0]);
    foreach (data[i]) begin
      send_hex_byte(data[i]);
      sum += data[i];
    end
    send_hex_byte(corrupt ? sum : ~sum);
    if (!corrupt) end_line();
  endtask

  task automatic send_header_line();
    send_char(CharS);
    send_char(CharZero + TypeHeader);
    repeat ($urandom_range(0, 12)) send_char(junk_char());
    send_char(CharLf);
  endtask

  task automatic send_random_record();
    logic [7:0]  data [$];
    logic [3:0]  rtype;
    logic [15:0] addr;
    int          pick;
    int          n;
    pick = $urandom_range(99);
    if (pick < 75) rtype = 4'($urandom_range(TypeRegister, TypeProgram));
    else if (pick < 87) rtype = 4'($urandom_range(TypeCheckLast, TypeCheckFirst));
    else rtype = TypeStart;
    n = ($urandom_range(19) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
    if (rtype == TypeStart && $urandom_range(3) != 0) n = 0;
    repeat (n) data.push_back(8'($urandom));
    addr = ($urandom_range(3) == 0) ? 16'hFFFF - 16'($urandom_range(15)) : 16'($urandom);
    send_record(rtype, addr, data);
  endtask

  task automatic read_back(input int n);
    int key;
    repeat (n) begin
      if (written_keys.size() == 0 || $urandom_range(9) == 0) begin
        send_read(BANK_NONE, 16'($urandom));
      end else begin
        key = written_keys[$urandom_range(written_keys.size() - 1)];
        send_read(2'(key / BankSize), 16'(key % BankSize));
      end
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  task automatic test_line_ends_and_header();
    send_char(CharLf);
    send_char(CharCr);
    send_char(CharS);
    send_char(CharZero + TypeHeader);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CharS);
    send_char(CharLf);
    send_header_line();
  endtask

  task automatic test_record_kinds();
    logic [7:0] data [$];
    data = '{8'h00, 8'hFF};
    send_record(TypeProgram, 16'h0000, data);
    data = '{8'h5A, 8'hA5};
    send_record(TypeData, 16'hFFFF, data);
    data = '{8'h12, 8'h34};
    send_record(TypeRegister, 16'hFFFE, data);
    data.delete();
    send_record(TypeCheckFirst + 4'd1, 16'h0000, data);
    send_record(TypeStart, 16'hFFFF, data);
    send_read(BANK_PROGRAM, 16'h0000);
    send_read(BANK_PROGRAM, 16'h0001);
    send_read(BANK_DATA, 16'hFFFF);
    send_read(BANK_DATA, 16'h0000);
    send_read(BANK_REGISTER, 16'hFFFE);
    send_read(BANK_REGISTER, 16'h0000);
    send_read(BANK_NONE, 16'hFFFF);
  endtask

  task automatic test_random_mix();
    logic [7:0] data [$];
    int         stop_at;
    bit         paused;
    stop_at = words_sent + 600;
    paused = 1'b0;
    sender_idle_pct = 15;
    sink_stall_pct = 15;
    repeat (252) data.push_back(8'($urandom));
    send_record(4'($urandom_range(TypeRegister, TypeProgram)), 16'($urandom), data);
    while (words_sent < stop_at) begin
      if ($urandom_range(5) == 0) begin
        sender_idle_pct = $urandom_range(2) * 15;
        sink_stall_pct = $urandom_range(2) * 15;
      end
      if ($urandom_range(11) == 0) send_header_line();
      else send_random_record();
      read_back($urandom_range(0, 4));
      if (!paused && words_sent > stop_at - 200) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  task automatic test_quiet_tail();
    sender_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (6) begin
      send_random_record();
      read_back(3);
    end
  endtask

  task automatic test_sticky_error();
    logic [7:0] data [$];
    logic [7:0] c;
    status_e    kind;
    kind = status_e'($urandom_range(int'(STAT_SHORT), int'(STAT_NO_S)));
    case (kind)
      STAT_NO_S: begin
        c = junk_char();
        while (c == CharS || c == CharCr) c = junk_char();
        send_char(c);
      end
      STAT_TYPE: begin
        send_char(CharS);
        c = 8'($urandom);
        while (c >= CharZero && c <= CharNine) c = 8'($urandom);
        send_char(c);
      end
      STAT_CSUM: begin
        repeat ($urandom_range(0, 4)) data.push_back(8'($urandom));
        send_record(4'($urandom_range(TypeRegister, TypeProgram)), 16'($urandom), data, 1'b1);
      end
      STAT_HEX: begin
        send_char(CharS);
        send_char(CharZero + TypeProgram);
        send_char(CharZero);
        c = ($urandom_range(1) != 0) ? CharLf : 8'($urandom);
        while (hex_nibble(c) >= 0) c = 8'($urandom);
        send_char(c);
      end
      default: begin
        send_char(CharS);
        send_char(CharZero + 4'($urandom_range(TypeStart, TypeProgram)));
        send_hex_byte(8'($urandom_range(int'(MinLength) - 1)));
      end
    endcase
    send_random_record();
    repeat (8) send_char(8'($urandom));
    read_back(8);
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: status %0d pc %h data %h", out_ch.payload.status,
                   out_ch.payload.program_counter, out_ch.payload.read_data);
        end
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.payload.status !== want.status ||
            out_ch.payload.program_counter !== want.program_counter ||
            out_ch.payload.read_data !== want.read_data) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: status %0d/%0d pc %h/%h data %h/%h (expected/actual)",
                     want.status, out_ch.payload.status, want.program_counter,
                     out_ch.payload.program_counter, want.read_data, out_ch.payload.read_data);
          end
        end
      end
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    out_ch.ready <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_line_ends_and_header();
    test_record_kinds();
    test_random_mix();
    test_quiet_tail();
    test_sticky_error();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
